// ===== rtl/tpwm_pkg.sv =====
// Package for the three-phase table PWM generator.
// Holds the channel payload types, the phase constants and the pulse mode codes.
// It has no dependencies.
package tpwm_pkg;

   localparam int PHASE_W = 32;

   // V and W lead U by 240 and 120 degrees of the 32-bit phase circle
   localparam logic [PHASE_W-1:0] OFFSET_V = 32'hAAAA_AAAA;
   localparam logic [PHASE_W-1:0] OFFSET_W = 32'h5555_5555;

   // Half-cycle flags after reset: bit0 = U, bit1 = V, bit2 = W
   localparam logic [2:0] HALF_RESET = 3'b011;

   // Item opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Pulse mode codes
   localparam logic [2:0] MODE_45P   = 3'd0;
   localparam logic [2:0] MODE_27P   = 3'd1;
   localparam logic [2:0] MODE_15P   = 3'd2;
   localparam logic [2:0] MODE_9P    = 3'd3;
   localparam logic [2:0] MODE_5P    = 3'd4;
   localparam logic [2:0] MODE_3P    = 3'd5;
   localparam logic [2:0] MODE_1P    = 3'd6;
   localparam logic [2:0] MODE_UNDEF = 3'd7;

   // Modulation bytes
   localparam logic [7:0] ALPHA_FULL = 8'hFF;
   localparam logic [7:0] ALPHA_MAX  = 8'hFE;

   typedef struct packed {
      logic        mode;
      logic [31:0] freq_step;
      logic [7:0]  volt_level;
      logic [2:0]  pmode_ref;
      logic        run;
      logic [2:0]  table_select;
      logic [13:0] table_address;
      logic [7:0]  table_byte;
   } req_payload_type;

   typedef struct packed {
      logic       drive_u;
      logic       drive_v;
      logic       drive_w;
      logic       shutdown;
      logic [2:0] active_mode;
   } rsp_payload_type;

endpackage

// ===== rtl/tpwm_if.sv =====
// Valid/ready channel interfaces for the PWM generator.
// Depends on tpwm_pkg for the payload types.
interface tpwm_req_if import tpwm_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tpwm_rsp_if import tpwm_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tpwm_wave_ram.sv =====
// Waveform table RAM: one write port, one registered read port.
// Holds all tables side by side; depends on nothing but its parameters.
module tpwm_wave_ram #(
   parameter int ADDR_BITS  = 14,
   parameter int NUM_TABLES = 6,
   parameter int IDX_W      = 3
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_sel,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_sel,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [NUM_TABLES][2**ADDR_BITS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_sel][wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_sel][rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/three_phase_table_pwm_generator.sv =====
// Top level of the three-phase table PWM generator.
// Depends on tpwm_pkg, tpwm_if and tpwm_wave_ram.
//
//   channel   dir  handshake          carries
//   req_chan  in   valid/ready        tick or table write item
//   rsp_chan  out  valid/ready        drive_u/v/w, shutdown, active_mode
//
// One item per cycle when rsp_chan is drained; a tick's result is registered and appears in the cycle
// after its transfer, a table write gives no result.
// The bits a tick computes are shown by the next tick: the three table reads of
// a tick land in the RAM read registers and are compared against the modulation
// byte when the following tick is transferred.
// Synchronous reset presets phases, mode and half-cycle flags, clears the PWM buffer;
// the tables are not cleared and must be loaded before ticks read them.
// req_chan.ready drops only while a result sits in the output register unclaimed.
module three_phase_table_pwm_generator import tpwm_pkg::*; #(
   parameter int TABLE_ADDR_BITS = 14,
   parameter int NUM_TABLES      = 6
) (
   input  logic        clock,
   input  logic        reset,
   tpwm_req_if.sink    req_chan,
   tpwm_rsp_if.source  rsp_chan
);

   localparam int TBL_IDX_W = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

   // Transfer decode
   logic req_xfer;
   logic tick_xfer;
   logic wr_xfer;

   // Phase accumulators, one per phase (U, V, W)
   logic [PHASE_W-1:0] phase_ff [3];
   logic [PHASE_W-1:0] phase_in [3];

   // Half-cycle flags; they double as the invert bits of the buffered compare
   logic [2:0] half_ff, half_in;
   logic [2:0] mode_ff, mode_in;
   logic [2:0] mode_req;
   logic [7:0] alpha_ff, alpha_in;
   logic       buf_vld_ff;

   logic [2:0]                 tbl_code;
   logic [TBL_IDX_W-1:0]       rd_sel;
   logic [TABLE_ADDR_BITS-1:0] rd_addr [3];
   logic [7:0]                 rd_data [3];
   logic [2:0]                 buf_bits;

   logic [TABLE_ADDR_BITS-1:0] wr_addr;
   logic [TBL_IDX_W-1:0]       wr_sel;

   // Output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign tick_xfer = req_xfer && (req_chan.data.mode == OP_TICK);
   // Writes to a table beyond the configured count are dropped
   assign wr_xfer   = req_xfer && (req_chan.data.mode == OP_WRITE) &&
                      ({1'b0, req_chan.data.table_select} < 4'(NUM_TABLES));

   assign wr_addr = TABLE_ADDR_BITS'(req_chan.data.table_address);
   assign wr_sel  = TBL_IDX_W'(req_chan.data.table_select);

   // Next phase, flags, mode, modulation byte and table read select for a tick
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         phase_in[i] = phase_ff[i] + req_chan.data.freq_step;
         rd_addr[i]  = phase_in[i][PHASE_W-2 -: TABLE_ADDR_BITS];
      end
      half_in = {phase_in[2][PHASE_W-1], phase_in[1][PHASE_W-1], phase_in[0][PHASE_W-1]};

      mode_req = (req_chan.data.pmode_ref == MODE_UNDEF) ? MODE_3P : req_chan.data.pmode_ref;
      // New mode only at a half-cycle boundary of any phase
      mode_in  = (half_in != half_ff) ? mode_req : mode_ff;

      if (mode_in == MODE_1P) begin
         alpha_in = ALPHA_FULL;
      end else if (req_chan.data.volt_level == ALPHA_FULL) begin
         alpha_in = ALPHA_MAX;
      end else begin
         alpha_in = req_chan.data.volt_level;
      end

      // One-pulse mode shares the 3P table; clamp to the last table present
      tbl_code = (mode_in <= MODE_5P) ? mode_in : MODE_3P;
      if ({1'b0, tbl_code} >= 4'(NUM_TABLES)) begin
         tbl_code = 3'(NUM_TABLES - 1);
      end
      rd_sel = TBL_IDX_W'(tbl_code);
   end

   // One table copy per phase so all three reads happen in the same cycle
   for (genvar g = 0; g < 3; g++) begin : g_ram
      tpwm_wave_ram #(
         .ADDR_BITS  (TABLE_ADDR_BITS),
         .NUM_TABLES (NUM_TABLES),
         .IDX_W      (TBL_IDX_W)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_xfer),
         .wr_sel  (wr_sel),
         .wr_addr (wr_addr),
         .wr_data (req_chan.data.table_byte),
         .rd_en   (tick_xfer),
         .rd_sel  (rd_sel),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   // Bits buffered by the previous tick: compare, then invert in the negative half
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         buf_bits[i] = buf_vld_ff && ((alpha_ff >= rd_data[i]) ^ half_ff[i]);
      end
   end

   always_comb begin
      rsp_data_in.drive_u     = buf_bits[0] && req_chan.data.run;
      rsp_data_in.drive_v     = buf_bits[1] && req_chan.data.run;
      rsp_data_in.drive_w     = buf_bits[2] && req_chan.data.run;
      rsp_data_in.shutdown    = !req_chan.data.run;
      rsp_data_in.active_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff[0] <= '0;
         phase_ff[1] <= OFFSET_V;
         phase_ff[2] <= OFFSET_W;
         half_ff     <= HALF_RESET;
         mode_ff     <= MODE_45P;
         buf_vld_ff  <= 1'b0;
      end else if (tick_xfer) begin
         for (int i = 0; i < 3; i++) begin
            phase_ff[i] <= phase_in[i];
         end
         half_ff    <= half_in;
         mode_ff    <= mode_in;
         buf_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_xfer) begin
         alpha_ff    <= alpha_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tick_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

// ===== rtl/tpwm_checker.sv =====
// Port-level checker for the PWM generator, bound to the top level.
// Depends on tpwm_pkg.
module tpwm_checker import tpwm_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A result appears only after a tick transfer
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_data.mode == OP_TICK)))
      else $error("result without a tick transfer");

   // Shutdown forces all gates low
   a_shutdown_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.shutdown) |->
         (!rsp_data.drive_u && !rsp_data.drive_v && !rsp_data.drive_w))
      else $error("gate drive active during shutdown");

   // The undefined mode request is remapped, never reported
   a_mode_defined: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.active_mode != MODE_UNDEF))
      else $error("undefined pulse mode reported");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind three_phase_table_pwm_generator tpwm_checker u_tpwm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_data  (req_chan.data),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
